/* src/sida_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned PROD_W = 64;

  // Reciprocal of ten, scaled by 2^35; exact quotient for any 32-bit unsigned operand.
  localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned QUOT_W = PROD_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prime;
    logic step;
    logic emit_sign;
    logic emit_digit;
  } sida_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic negative;
    logic step_last;
    logic idx_zero;
  } sida_status_t;

endpackage

/* src/signed_int_to_decimal_ascii.sv */
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
//   Channel   Ports                        Transfer
//   input     start, busy, value           rising edge with start high and busy low
//   output    strobe, character, last      rising edge that ends a cycle with strobe high
//
// A value is converted in order: the reciprocal product is formed, ten passes run through the
// divide-by-ten unit (one 32x32 multiply per cycle), then one character per cycle goes out;
// the next value can transfer only once busy falls after the last character.
// Reset is synchronous and returns the controller to idle with no strobe pending.
// The receiver cannot stall; characters leave at one per cycle.
module signed_int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sida_pkg::VALUE_W-1:0]  value,
  output logic [sida_pkg::CHAR_W-1:0]          character,
  output logic                                 last,
  output logic                                 strobe
);

  sida_pkg::sida_cmd_t    cmd;
  sida_pkg::sida_status_t status;

  sida_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  sida_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

endmodule

/* src/sida_datapath.sv */
// Datapath: magnitude, reciprocal divider by ten, digit store and character output.
module sida_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sida_pkg::sida_cmd_t                  cmd,
  output sida_pkg::sida_status_t               status,
  input  logic signed [sida_pkg::VALUE_W-1:0]  value,
  output logic [sida_pkg::CHAR_W-1:0]          character,
  output logic                                 last,
  output logic                                 strobe
);

  logic [sida_pkg::VALUE_W-1:0]  value_u;
  logic [sida_pkg::VALUE_W-1:0]  mag;
  logic [sida_pkg::PROD_W-1:0]   prod;
  logic [sida_pkg::QUOT_W-1:0]   quot;
  logic [sida_pkg::DIGIT_W-1:0]  quot_x10_lo;
  logic [sida_pkg::DIGIT_W-1:0]  digit;
  logic [sida_pkg::DIGIT_W-1:0]  digits [sida_pkg::NUM_DIGITS];
  logic [sida_pkg::IDX_W-1:0]    cnt;
  logic [sida_pkg::IDX_W-1:0]    top;
  logic [sida_pkg::IDX_W-1:0]    idx;
  logic                          negative;

  assign value_u = $unsigned(value);

  // Quotient from the registered product; the remainder needs only the low four bits.
  assign quot = prod[sida_pkg::PROD_W-1:sida_pkg::RECIP_SHIFT];
  assign quot_x10_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit = mag[sida_pkg::DIGIT_W-1:0] - quot_x10_lo;

  // Magnitude and product registers: one division by ten per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value_u[sida_pkg::VALUE_W-1];
      mag <= value_u[sida_pkg::VALUE_W-1] ? (32'd0 - value_u) : value_u;
    end else if (cmd.prime) begin
      prod <= mag * sida_pkg::RECIP_TEN;
    end else if (cmd.step) begin
      mag <= sida_pkg::VALUE_W'(quot);
      prod <= sida_pkg::VALUE_W'(quot) * sida_pkg::RECIP_TEN;
    end
  end

  // Digit store, filled least significant first, and index of the top nonzero digit.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      digits[cnt] <= digit;
      if (digit != '0) begin
        top <= cnt;
      end
    end else if (cmd.prime) begin
      top <= '0;
    end
  end

  // Step counter and emit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else begin
      if (cmd.prime) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= cnt + 1'b1;
        if (status.step_last) begin
          idx <= (digit != '0) ? cnt : top;
        end
      end else if (cmd.emit_digit) begin
        idx <= idx - 1'b1;
      end
    end
  end

  assign status.negative = negative;
  assign status.step_last = (cnt == sida_pkg::IDX_W'(sida_pkg::NUM_DIGITS - 1));
  assign status.idx_zero = (idx == '0);

  // Output register: one character per strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= sida_pkg::ASCII_MINUS;
      last <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(digits[idx]);
      last <= (idx == '0);
    end
  end

endmodule

/* src/sida_controller.sv */
// Controller state machine: sequences load, division steps and character output.
module sida_controller (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output sida_pkg::sida_cmd_t     cmd,
  input  sida_pkg::sida_status_t  status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PRIME = 5'b00010,
    S_CONV  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.prime = 1'b1;
        state_next = S_CONV;
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (status.step_last) begin
          state_next = status.negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (status.idx_zero) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* tb/sv/signed_int_to_decimal_ascii_tb.sv */
// Self-checking testbench for the signed 32-bit integer to decimal ASCII text converter.
module signed_int_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_TAIL = 40;
  localparam int STRETCH_LEN = 25;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_ROWS = 20;

  // One expected character of a value's text.
  typedef struct {
    logic [sida_pkg::CHAR_W-1:0] ch;
    logic                        fin;
  } text_char_t;

  // Directed stimulus row; an empty text means the predictor supplies the expectation.
  typedef struct {
    logic [sida_pkg::VALUE_W-1:0] val;
    string                        text;
  } directed_row_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic signed [sida_pkg::VALUE_W-1:0] value;
  logic [sida_pkg::CHAR_W-1:0]         character;
  logic                                last;
  logic                                strobe;

  text_char_t expected_chars [$];
  text_char_t head_char;
  int         error_count = 0;
  int         stall_cycles = 0;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    '{32'd0,           "0"},
    '{32'h8000_0000,   "-2147483648"},
    '{32'h7FFF_FFFF,   "2147483647"},
    '{32'hFFFF_FFFF,   "-1"},
    '{32'd1,           "1"},
    '{32'd9,           "9"},
    '{32'd10,          "10"},
    '{-32'sd10,        "-10"},
    '{32'd1000000000,  "1000000000"},
    '{-32'sd999999999, "-999999999"},
    '{32'd99,          ""},
    '{32'd100,         ""},
    '{-32'sd100,       ""},
    '{32'h5555_5555,   ""},
    '{32'hAAAA_AAAA,   ""},
    '{32'h8000_0001,   ""},
    '{32'h0000_FFFF,   ""},
    '{32'hFFFF_0000,   ""},
    '{32'd123456789,   ""},
    '{-32'sd98765,     ""}
  };

  signed_int_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .character (character),
    .last      (last),
    .strobe    (strobe)
  );

  always #4 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Queue the decimal text of a value: optional sign, then digits from the most significant.
  function automatic void predict_text(input logic [sida_pkg::VALUE_W-1:0] v);
    logic [sida_pkg::VALUE_W-1:0] mag;
    int                           digit_buf [sida_pkg::NUM_DIGITS];
    int                           count;
    text_char_t                   c;
    mag = v[sida_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
    if (v[sida_pkg::VALUE_W-1]) begin
      c.ch = sida_pkg::ASCII_MINUS;
      c.fin = 1'b0;
      expected_chars.push_back(c);
    end
    count = 0;
    do begin
      digit_buf[count] = int'(mag % 10);
      count++;
      mag = mag / 10;
    end while (mag != 0);
    for (int k = count - 1; k >= 0; k--) begin
      c.ch = sida_pkg::ASCII_ZERO + 8'(digit_buf[k]);
      c.fin = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Queue text typed in directly, flagging its final character.
  function automatic void expect_text(input string s);
    text_char_t c;
    for (int k = 0; k < s.len(); k++) begin
      c.ch = s[k];
      c.fin = (k == s.len() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  // Random value with a spread of text lengths, signs and power-of-ten boundaries.
  function automatic logic [sida_pkg::VALUE_W-1:0] random_value();
    logic [sida_pkg::VALUE_W-1:0] r;
    logic [sida_pkg::VALUE_W-1:0] scale;
    int unsigned                  ndigits;
    scale = 1;
    ndigits = $urandom_range(1, 9);
    for (int k = 1; k < ndigits; k++) scale = scale * 10;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: r = $urandom_range(0, 99);
      2: r = $urandom_range(scale * 10 - 1, scale);
      default: r = scale * 10 + $urandom_range(0, 2) - 1;
    endcase
    if ($urandom_range(0, 1) == 1) r = ~r + 1'b1;
    return r;
  endfunction

  // Present one value, optionally after an idle burst, and hold it until the transfer.
  task automatic send_value(input logic [sida_pkg::VALUE_W-1:0] v, input string text,
                            input bit gaps_on);
    int gap;
    if (gaps_on && $urandom_range(0, 9) < 4) begin
      gap = $urandom_range(1, 14);
      start <= 1'b0;
      value <= $urandom();
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    if (text.len() != 0) expect_text(text);
    else predict_text(v);
    @(negedge clk);
  endtask

  // Compare each strobed character with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        flag_error($sformatf("unexpected character 0x%02h last=%0b", character, last));
      end else begin
        head_char = expected_chars.pop_front();
        if (character !== head_char.ch)
          flag_error($sformatf("character 0x%02h, expected 0x%02h", character, head_char.ch));
        if (last !== head_char.fin)
          flag_error($sformatf("last %0b, expected %0b", last, head_char.fin));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: reset, directed table, a full drain, random values, then the final verdict.
  initial begin
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_value(directed_rows[i].val, directed_rows[i].text, 1'b1);

    // Hold off the sender until every character so far has come out.
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_value(random_value(), "",
                 (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / STRETCH_LEN) % 2 == 0));
    end
    start <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/sida_pkg.sv
src/sida_datapath.sv
src/sida_controller.sv
src/signed_int_to_decimal_ascii.sv
tb/sv/signed_int_to_decimal_ascii_tb.sv
